/* rtl/core/cmt_pkg.sv */
`default_nettype none

package cmt_pkg;

  localparam int unsigned ActionW   = 2;
  localparam int unsigned KeyInW    = 32;
  localparam int unsigned IndexW    = 4;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned CountOutW = 16;
  localparam int unsigned FillW     = 5;

  typedef enum logic [ActionW-1:0] {
    ACT_ADD,
    ACT_DELETE,
    ACT_REPLACE,
    ACT_READ
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK,
    ST_MISSING,
    ST_FULL,
    ST_RANGE
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_HIT,
    S_MISS,
    S_SHIFT,
    S_RDWAIT,
    S_RDOUT
  } state_e;

endpackage

`default_nettype wire

/* rtl/core/cmt_if.sv */
`default_nettype none

interface cmt_in_if;
  logic                           valid;
  logic                           ready;
  logic [cmt_pkg::ActionW-1:0]    action;
  logic [cmt_pkg::KeyInW-1:0]     key;
  logic [cmt_pkg::KeyInW-1:0]     new_key;
  logic [cmt_pkg::IndexW-1:0]     index;

  modport source (output valid, action, key, new_key, index, input ready);
  modport sink   (input valid, action, key, new_key, index, output ready);
endinterface

interface cmt_out_if;
  logic                           valid;
  logic                           ready;
  logic [cmt_pkg::StatusW-1:0]    status;
  logic [cmt_pkg::KeyInW-1:0]     entry_key;
  logic [cmt_pkg::CountOutW-1:0]  entry_count;
  logic [cmt_pkg::FillW-1:0]      fill;

  modport source (output valid, status, entry_key, entry_count, fill, input ready);
  modport sink   (input valid, status, entry_key, entry_count, fill, output ready);
endinterface

`default_nettype wire

/* rtl/core/counted_multiset_table.sv */
// A read returns the entry at its index; a read out of range is answered from the idle state
// with an out-of-range status. Add, delete and replace search the entries in order from the first
// and stop at the key or after the last entry (an empty table skips the search); a delete that
// removes an entry below the last moves the later entries down. The next item is taken only once
// the result has been taken, and the search and the shift walk the single read port in turn.
// Reset clears the fill level and control state; the memory contents are not cleared.
`default_nettype none

module counted_multiset_table #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cmt_in_if.sink     in_i,
  cmt_out_if.source  out_o
);

  import cmt_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned UW = $clog2(DEPTH + 1);

  state_e                state_q, state_d;
  action_e               act_q, act_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [KEY_BITS-1:0]   nkey_q, nkey_d;
  logic [IndexW-1:0]     idx_q, idx_d;
  logic [UW-1:0]         used_q, used_d;
  logic [AW-1:0]         ptr_q, ptr_d;
  logic                  issue_q, issue_d;
  logic                  chk_q, chk_d;
  logic [AW-1:0]         chk_ptr_q, chk_ptr_d;
  logic [AW-1:0]         pos_q, pos_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;

  logic                  out_valid_q;
  status_e               res_status_q, res_status;
  logic [KeyInW-1:0]     res_key_q, res_key;
  logic [CountOutW-1:0]  res_cnt_q, res_cnt;
  logic [FillW-1:0]      res_fill_q;
  logic [31:0]           fill_ext;
  logic                  fin;

  logic [AW-1:0]         rd_addr;
  logic [KEY_BITS-1:0]   rd_key;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic                  we;
  logic [AW-1:0]         wr_addr;
  logic [KEY_BITS-1:0]   wr_key;
  logic [COUNT_BITS-1:0] wr_cnt;

  logic                  in_acc;
  logic                  idx_ok;
  logic [AW-1:0]         last;
  logic                  hit;
  logic                  miss_end;
  logic                  shift_done;

  cmt_store #(
    .DEPTH      (DEPTH),
    .KEY_BITS   (KEY_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_store (
    .clk_i     (clk_i),
    .rd_addr_i (rd_addr),
    .rd_key_o  (rd_key),
    .rd_cnt_o  (rd_cnt),
    .we_i      (we),
    .wr_addr_i (wr_addr),
    .wr_key_i  (wr_key),
    .wr_cnt_i  (wr_cnt)
  );

  assign in_i.ready = (state_q == S_IDLE) && !out_valid_q;
  assign in_acc     = in_i.valid && in_i.ready;
  assign idx_ok     = 32'(in_i.index) < 32'(used_q);
  assign last       = AW'(used_q - UW'(1));
  assign hit        = chk_q && (rd_key == key_q);
  assign miss_end   = chk_q && !hit && (chk_ptr_q == last);
  assign shift_done = !issue_q && !chk_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (action_e'(in_i.action) == ACT_READ) begin
            state_d = idx_ok ? S_RDWAIT : S_IDLE;
          end else begin
            state_d = (used_q == '0) ? S_MISS : S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        priority if (hit) begin
          state_d = S_HIT;
        end else if (miss_end) begin
          state_d = S_MISS;
        end
      end
      S_HIT: begin
        if (act_q == ACT_DELETE && cnt_q <= COUNT_BITS'(1) && pos_q != last) begin
          state_d = S_SHIFT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SHIFT: begin
        if (shift_done) begin
          state_d = S_IDLE;
        end
      end
      S_MISS:   state_d = S_IDLE;
      S_RDWAIT: state_d = S_RDOUT;
      S_RDOUT:  state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    act_d      = act_q;
    key_d      = key_q;
    nkey_d     = nkey_q;
    idx_d      = idx_q;
    used_d     = used_q;
    ptr_d      = ptr_q;
    issue_d    = issue_q;
    chk_d      = chk_q;
    chk_ptr_d  = chk_ptr_q;
    pos_d      = pos_q;
    cnt_d      = cnt_q;
    rd_addr    = ptr_q;
    we         = 1'b0;
    wr_addr    = pos_q;
    wr_key     = key_q;
    wr_cnt     = cnt_q;
    fin        = 1'b0;
    res_status = ST_OK;
    res_key    = '0;
    res_cnt    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          act_d   = action_e'(in_i.action);
          key_d   = KEY_BITS'(in_i.key);
          nkey_d  = KEY_BITS'(in_i.new_key);
          idx_d   = in_i.index;
          ptr_d   = '0;
          issue_d = 1'b1;
          chk_d   = 1'b0;
          if (action_e'(in_i.action) == ACT_READ && !idx_ok) begin
            fin        = 1'b1;
            res_status = ST_RANGE;
          end
        end
      end
      S_SEARCH: begin
        rd_addr   = ptr_q;
        chk_d     = issue_q;
        chk_ptr_d = ptr_q;
        if (issue_q) begin
          if (ptr_q == last) begin
            issue_d = 1'b0;
          end else begin
            ptr_d = ptr_q + AW'(1);
          end
        end
        pos_d = chk_ptr_q;
        cnt_d = rd_cnt;
      end
      S_HIT: begin
        wr_addr = pos_q;
        wr_key  = key_q;
        wr_cnt  = cnt_q;
        unique case (act_q)
          ACT_ADD: begin
            we  = 1'b1;
            fin = 1'b1;
            if (cnt_q != '1) begin
              wr_cnt = cnt_q + COUNT_BITS'(1);
            end
          end
          ACT_REPLACE: begin
            we     = 1'b1;
            fin    = 1'b1;
            wr_key = nkey_q;
          end
          ACT_DELETE: begin
            if (cnt_q > COUNT_BITS'(1)) begin
              we     = 1'b1;
              fin    = 1'b1;
              wr_cnt = cnt_q - COUNT_BITS'(1);
            end else if (pos_q == last) begin
              fin    = 1'b1;
              used_d = used_q - UW'(1);
            end else begin
              ptr_d   = pos_q + AW'(1);
              issue_d = 1'b1;
              chk_d   = 1'b0;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      S_SHIFT: begin
        rd_addr   = ptr_q;
        chk_d     = issue_q;
        chk_ptr_d = ptr_q;
        if (issue_q) begin
          ptr_d   = ptr_q + AW'(1);
          issue_d = (ptr_q != last);
        end
        if (chk_q) begin
          we      = 1'b1;
          wr_addr = chk_ptr_q - AW'(1);
          wr_key  = rd_key;
          wr_cnt  = rd_cnt;
        end
        if (shift_done) begin
          fin    = 1'b1;
          used_d = used_q - UW'(1);
        end
      end
      S_MISS: begin
        fin = 1'b1;
        if (act_q == ACT_ADD) begin
          if (used_q >= UW'(DEPTH)) begin
            res_status = ST_FULL;
          end else begin
            we      = 1'b1;
            wr_addr = AW'(used_q);
            wr_key  = key_q;
            wr_cnt  = COUNT_BITS'(1);
            used_d  = used_q + UW'(1);
          end
        end else begin
          res_status = ST_MISSING;
        end
      end
      S_RDWAIT: begin
        rd_addr = AW'(idx_q);
      end
      S_RDOUT: begin
        fin     = 1'b1;
        res_key = KeyInW'(rd_key);
        res_cnt = CountOutW'(rd_cnt);
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  assign fill_ext = 32'(used_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      issue_q     <= 1'b0;
      chk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      issue_q <= issue_d;
      chk_q   <= chk_d;
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    key_q     <= key_d;
    nkey_q    <= nkey_d;
    idx_q     <= idx_d;
    ptr_q     <= ptr_d;
    chk_ptr_q <= chk_ptr_d;
    pos_q     <= pos_d;
    cnt_q     <= cnt_d;
    if (fin) begin
      res_status_q <= res_status;
      res_key_q    <= res_key;
      res_cnt_q    <= res_cnt;
      res_fill_q   <= fill_ext[FillW-1:0];
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = res_status_q;
  assign out_o.entry_key   = res_key_q;
  assign out_o.entry_count = res_cnt_q;
  assign out_o.fill        = res_fill_q;

  a_used_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UW'(DEPTH))
    else $error("The fill level has passed the table depth.");

  a_used_on_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(used_q) |-> $past(fin))
    else $error("The fill level changed without an item finishing.");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_i.ready)
    else $error("A new item was offered ready while one was still in hand.");

  a_range_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_status_q != ST_OK) |-> (res_key_q == '0 && res_cnt_q == '0))
    else $error("A failed item carries a non-zero entry.");

  a_write_below_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (32'(wr_addr) <= 32'(used_q)))
    else $error("A memory write landed above the fill level.");

endmodule

`default_nettype wire

/* rtl/core/cmt_store.sv */
`default_nettype none

module cmt_store #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned COUNT_BITS = 16,
  localparam int unsigned AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic [AW-1:0]         rd_addr_i,
  output logic      [KEY_BITS-1:0]   rd_key_o,
  output logic      [COUNT_BITS-1:0] rd_cnt_o,
  input  wire logic                  we_i,
  input  wire logic [AW-1:0]         wr_addr_i,
  input  wire logic [KEY_BITS-1:0]   wr_key_i,
  input  wire logic [COUNT_BITS-1:0] wr_cnt_i
);

  logic [KEY_BITS-1:0]   key_mem [DEPTH];
  logic [COUNT_BITS-1:0] cnt_mem [DEPTH];
  logic [KEY_BITS-1:0]   rd_key_q;
  logic [COUNT_BITS-1:0] rd_cnt_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_mem[wr_addr_i] <= wr_key_i;
      cnt_mem[wr_addr_i] <= wr_cnt_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_key_q <= key_mem[rd_addr_i];
    rd_cnt_q <= cnt_mem[rd_addr_i];
  end

  assign rd_key_o = rd_key_q;
  assign rd_cnt_o = rd_cnt_q;

endmodule

`default_nettype wire

/* tb/tb_counted_multiset_table.sv */
`timescale 1ns / 1ps

module tb_counted_multiset_table;
  import cmt_pkg::*;

  localparam int TableDepth = 16;
  localparam logic [CountOutW-1:0] CountMax = '1;
  localparam int QuietLimit = 4000;
  localparam int RepeatAdds = 20;

  typedef struct packed {
    status_e               status;
    logic [KeyInW-1:0]     entry_key;
    logic [CountOutW-1:0]  entry_count;
    logic [FillW-1:0]      fill;
  } table_result_t;

  logic clk_i;
  logic rst_ni;

  cmt_in_if  in_if ();
  cmt_out_if out_if ();

  counted_multiset_table i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  logic [KeyInW-1:0]    tbl_key   [TableDepth];
  logic [CountOutW-1:0] tbl_count [TableDepth];
  int                   tbl_fill;

  table_result_t pending_results [$];
  logic [KeyInW-1:0] key_pool [24];

  logic stall_en;
  int   mismatches;
  int   results_checked;
  int   items_sent;
  int   quiet_cycles;
  int   action_seen [4];
  int   status_seen [4];

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic table_result_t apply_action(input action_e act, input logic [KeyInW-1:0] k,
                                                 input logic [KeyInW-1:0] nk,
                                                 input logic [IndexW-1:0] idx);
    table_result_t res;
    int pos;
    res.status      = ST_OK;
    res.entry_key   = '0;
    res.entry_count = '0;
    pos = TableDepth;
    for (int i = tbl_fill - 1; i >= 0; i--) begin
      if (tbl_key[i] == k) pos = i;
    end
    case (act)
      ACT_ADD: begin
        if (pos < TableDepth) begin
          if (tbl_count[pos] != CountMax) tbl_count[pos]++;
        end else if (tbl_fill >= TableDepth) begin
          res.status = ST_FULL;
        end else begin
          tbl_key[tbl_fill]   = k;
          tbl_count[tbl_fill] = CountOutW'(1);
          tbl_fill++;
        end
      end
      ACT_DELETE: begin
        if (pos == TableDepth) begin
          res.status = ST_MISSING;
        end else if (tbl_count[pos] <= 1) begin
          for (int i = pos; i + 1 < tbl_fill; i++) begin
            tbl_key[i]   = tbl_key[i + 1];
            tbl_count[i] = tbl_count[i + 1];
          end
          tbl_fill--;
        end else begin
          tbl_count[pos]--;
        end
      end
      ACT_REPLACE: begin
        if (pos == TableDepth) res.status = ST_MISSING;
        else tbl_key[pos] = nk;
      end
      default: begin
        if (int'(idx) >= tbl_fill) begin
          res.status = ST_RANGE;
        end else begin
          res.entry_key   = tbl_key[idx];
          res.entry_count = tbl_count[idx];
        end
      end
    endcase
    res.fill = tbl_fill[FillW-1:0];
    action_seen[int'(act)]++;
    status_seen[int'(res.status)]++;
    return res;
  endfunction

  task automatic send_item(input action_e act, input logic [KeyInW-1:0] k,
                           input logic [KeyInW-1:0] nk, input logic [IndexW-1:0] idx);
    while (stall_en && $urandom_range(0, 99) < 21) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.action  <= act;
    in_if.key     <= k;
    in_if.new_key <= nk;
    in_if.index   <= idx;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    pending_results.push_back(apply_action(act, k, nk, idx));
    items_sent++;
  endtask

  function automatic logic [KeyInW-1:0] pick_key();
    if ($urandom_range(0, 99) < 80) return key_pool[$urandom_range(0, 23)];
    return $urandom();
  endfunction

  function automatic logic [IndexW-1:0] rand_idx();
    return IndexW'($urandom_range(0, 15));
  endfunction

  task automatic test_empty_table();
    send_item(ACT_READ, $urandom(), $urandom(), 4'd0);
    send_item(ACT_DELETE, 32'hFFFF_FFFF, $urandom(), rand_idx());
    send_item(ACT_REPLACE, 32'h0000_0000, 32'h0000_0000, rand_idx());
    send_item(ACT_READ, $urandom(), $urandom(), 4'd15);
  endtask

  task automatic test_repeated_adds();
    stall_en = 1'b0;
    for (int n = 0; n < RepeatAdds; n++) begin
      send_item(ACT_ADD, 32'h0000_0000, $urandom(), rand_idx());
    end
    send_item(ACT_READ, $urandom(), $urandom(), 4'd0);
    send_item(ACT_DELETE, 32'h0000_0000, $urandom(), rand_idx());
    send_item(ACT_READ, $urandom(), $urandom(), 4'd0);
    stall_en = 1'b1;
  endtask

  task automatic test_fill_and_remove();
    send_item(ACT_ADD, 32'hFFFF_FFFF, $urandom(), rand_idx());
    while (tbl_fill < TableDepth) begin
      send_item(ACT_ADD, $urandom(), $urandom(), rand_idx());
    end
    send_item(ACT_ADD, 32'hDEAD_0001, $urandom(), rand_idx());
    send_item(ACT_ADD, 32'hFFFF_FFFF, $urandom(), rand_idx());
    send_item(ACT_READ, $urandom(), $urandom(), 4'd15);
    send_item(ACT_REPLACE, tbl_key[5], 32'hFFFF_FFFF, rand_idx());
    repeat (3) send_item(ACT_DELETE, 32'hFFFF_FFFF, $urandom(), rand_idx());
    send_item(ACT_READ, $urandom(), $urandom(), 4'd15);
    send_item(ACT_READ, $urandom(), $urandom(), 4'd14);
  endtask

  task automatic test_random_actions();
    int pick;
    action_e act;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 24; i++) key_pool[i] = $urandom();
    for (int blk = 0; blk < 22; blk++) begin
      stall_en = !(blk >= 8 && blk < 12);
      for (int n = 0; n < 50; n++) begin
        pick = $urandom_range(0, 99);
        if (blk % 2 == 0) begin
          act = (pick < 55) ? ACT_ADD : (pick < 70) ? ACT_DELETE :
                (pick < 80) ? ACT_REPLACE : ACT_READ;
        end else begin
          act = (pick < 15) ? ACT_ADD : (pick < 65) ? ACT_DELETE :
                (pick < 75) ? ACT_REPLACE : ACT_READ;
        end
        send_item(act, pick_key(), pick_key(), rand_idx());
      end
    end
    stall_en = 1'b1;
  endtask

  always @(posedge clk_i) begin
    out_if.ready <= !stall_en || ($urandom_range(0, 99) >= 21);
  end

  always @(posedge clk_i) begin : check_results
    table_result_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: status %0d key %h count %0d fill %0d",
                   out_if.status, out_if.entry_key, out_if.entry_count, out_if.fill);
        end
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_if.status !== want.status || out_if.entry_key !== want.entry_key ||
            out_if.entry_count !== want.entry_count || out_if.fill !== want.fill) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d: expected status %0d key %h count %0d fill %0d",
                     results_checked, want.status, want.entry_key, want.entry_count,
                     want.fill);
            $display("result %0d: actual   status %0d key %h count %0d fill %0d",
                     results_checked, out_if.status, out_if.entry_key,
                     out_if.entry_count, out_if.fill);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_ni          <= 1'b0;
    stall_en         = 1'b1;
    in_if.valid     <= 1'b0;
    in_if.action    <= ACT_READ;
    in_if.key       <= '0;
    in_if.new_key   <= '0;
    in_if.index     <= '0;
    tbl_fill         = 0;
    items_sent       = 0;
    for (int i = 0; i < 4; i++) begin
      action_seen[i] = 0;
      status_seen[i] = 0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_repeated_adds();
    test_fill_and_remove();
    test_random_actions();

    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("%0d items sent (%0d add, %0d delete, %0d replace, %0d read), %0d results checked.",
             items_sent, action_seen[ACT_ADD], action_seen[ACT_DELETE],
             action_seen[ACT_REPLACE], action_seen[ACT_READ], results_checked);
    $display("Status seen: %0d ok, %0d missing key, %0d full, %0d out of range; %0d mismatches.",
             status_seen[ST_OK], status_seen[ST_MISSING], status_seen[ST_FULL],
             status_seen[ST_RANGE], mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
